FILE: rtl/sincx5_pkg.sv
// Shared types, constants, kernel table and microprogram of the x5 sinc interpolator.
package sincx5_pkg;

    localparam int TAPS      = 10;
    localparam int PHASES    = 5;
    localparam int TAP_W     = 4;
    localparam int PH_W      = 3;
    localparam int SAMPLE_W  = 8;
    localparam int KERN_W    = 19;
    localparam int ACC_W     = 29;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = DATA_W + ACC_W;
    localparam int SHIFT     = 30;
    localparam int STEP_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd2;

    localparam logic signed [KERN_W-1:0] PASS_KERN = 19'sd200000;

    // Microprogram step addresses
    localparam logic [STEP_W-1:0] ST_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] ST_INIT   = 4'd1;
    localparam logic [STEP_W-1:0] ST_MODE   = 4'd2;
    localparam logic [STEP_W-1:0] ST_PASS   = 4'd3;
    localparam logic [STEP_W-1:0] ST_MAC    = 4'd4;
    localparam logic [STEP_W-1:0] ST_MUL    = 4'd5;
    localparam logic [STEP_W-1:0] ST_SCALE  = 4'd6;
    localparam logic [STEP_W-1:0] ST_EMIT   = 4'd7;
    localparam logic [STEP_W-1:0] ST_NEXT   = 4'd8;
    localparam logic [STEP_W-1:0] ST_UPDATE = 4'd9;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INIT,
        OP_PASS,
        OP_MAC,
        OP_MUL,
        OP_SCALE,
        OP_EMIT,
        OP_NEXT,
        OP_UPDATE
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_COLD,
        C_UP,
        C_TAP_MORE,
        C_OUT_BUSY,
        C_PHASE_MORE
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic no_in;
        logic cold;
        logic up;
        logic tap_more;
        logic out_busy;
        logic phase_more;
    } t_flags;

    function automatic t_ctrl prog_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{op: OP_NONE, cond: C_ALWAYS, target: ST_WAIT};
        unique case (step)
            ST_WAIT:   w = '{op: OP_ACCEPT, cond: C_NO_IN,      target: ST_WAIT};
            ST_INIT:   w = '{op: OP_INIT,   cond: C_COLD,       target: ST_UPDATE};
            ST_MODE:   w = '{op: OP_NONE,   cond: C_UP,         target: ST_MAC};
            ST_PASS:   w = '{op: OP_PASS,   cond: C_ALWAYS,     target: ST_MUL};
            ST_MAC:    w = '{op: OP_MAC,    cond: C_TAP_MORE,   target: ST_MAC};
            ST_MUL:    w = '{op: OP_MUL,    cond: C_NEVER,      target: ST_WAIT};
            ST_SCALE:  w = '{op: OP_SCALE,  cond: C_NEVER,      target: ST_WAIT};
            ST_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,   target: ST_EMIT};
            ST_NEXT:   w = '{op: OP_NEXT,   cond: C_PHASE_MORE, target: ST_MAC};
            ST_UPDATE: w = '{op: OP_UPDATE, cond: C_ALWAYS,     target: ST_WAIT};
            default:   w = '{op: OP_NONE,   cond: C_ALWAYS,     target: ST_WAIT};
        endcase
        return w;
    endfunction

    typedef logic signed [KERN_W-1:0] t_kern;

    function automatic t_kern kern(input logic [TAP_W-1:0] tap, input logic [PH_W-1:0] ph);
        t_kern r0, r1, r2, r3, r4;
        {r0, r1, r2, r3, r4} = '0;
        unique case (tap)
            4'd0: {r0, r1, r2, r3, r4} = {19'sd0, 19'sd626, 19'sd1432, 19'sd1942, 19'sd1579};
            4'd1: {r0, r1, r2, r3, r4} = {19'sd0, -19'sd2556, -19'sd5136, -19'sd6299,
                                          -19'sd4726};
            4'd2: {r0, r1, r2, r3, r4} = {19'sd0, 19'sd6803, 19'sd13096, 19'sd15526,
                                          19'sd11354};
            4'd3: {r0, r1, r2, r3, r4} = {19'sd0, -19'sd15926, -19'sd30697, -19'sd36878,
                                          -19'sd27753};
            4'd4: {r0, r1, r2, r3, r4} = {19'sd0, 19'sd44430, 19'sd98040, 19'sd149440,
                                          19'sd186501};
            4'd5: {r0, r1, r2, r3, r4} = {19'sd200000, 19'sd186501, 19'sd149440, 19'sd98040,
                                          19'sd44430};
            4'd6: {r0, r1, r2, r3, r4} = {19'sd0, -19'sd27753, -19'sd36878, -19'sd30697,
                                          -19'sd15926};
            4'd7: {r0, r1, r2, r3, r4} = {19'sd0, 19'sd11354, 19'sd15526, 19'sd13096,
                                          19'sd6803};
            4'd8: {r0, r1, r2, r3, r4} = {19'sd0, -19'sd4726, -19'sd6299, -19'sd5136,
                                          -19'sd2556};
            4'd9: {r0, r1, r2, r3, r4} = {19'sd0, 19'sd1579, 19'sd1942, 19'sd1432, 19'sd626};
            default: {r0, r1, r2, r3, r4} = '0;
        endcase
        unique case (ph)
            3'd0:    return r0;
            3'd1:    return r1;
            3'd2:    return r2;
            3'd3:    return r3;
            3'd4:    return r4;
            default: return '0;
        endcase
    endfunction

endpackage

FILE: rtl/sincx5_seq.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
module sincx5_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sincx5_pkg::t_flags            i_flags,
    output sincx5_pkg::t_ctrl             o_ctrl,
    output logic [sincx5_pkg::STEP_W-1:0] o_step
);
    import sincx5_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;
    logic              take;

    assign ctrl = prog_word(r_step);

    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_IN:      take = i_flags.no_in;
            C_COLD:       take = i_flags.cold;
            C_UP:         take = i_flags.up;
            C_TAP_MORE:   take = i_flags.tap_more;
            C_OUT_BUSY:   take = i_flags.out_busy;
            C_PHASE_MORE: take = i_flags.phase_more;
            default:      take = 1'b0;
        endcase
        n_step = take ? ctrl.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;
    assign o_step = r_step;

endmodule

FILE: rtl/sinc_upsample_x5_scaler_core.sv
// Top level: x5 sinc polyphase interpolator and gain/offset scaler with microcoded control.
// Pass mode: each input gives one result by pass, multiply, scale and emit steps. Upsample
// mode: each input gives five results, each by MAC steps over all ten taps, then multiply,
// scale and emit. While the window fills, an input only updates the delay line. A new input
// is taken only in the wait step, once the previous input's program has ended.
// Reset (synchronous, active low): delay line, fill count, config, out valid and step clear.
module sinc_upsample_x5_scaler_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [sincx5_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic                                   i_frame_end,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [sincx5_pkg::DATA_W-1:0]   o_value,
    output logic                                   o_last,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [sincx5_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sincx5_pkg::DATA_W-1:0]          i_cfg_data
);
    import sincx5_pkg::*;

    // Configuration registers
    logic                     r_up;
    logic signed [DATA_W-1:0] r_gain;
    logic signed [DATA_W-1:0] r_offset;

    // Sample history and latched transaction
    logic [SAMPLE_W-1:0] r_delay [TAPS-1];
    logic [TAP_W-1:0]    r_fill;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_fe;

    // Datapath registers
    logic [TAP_W-1:0]         r_tap;
    logic [PH_W-1:0]          r_phase;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_res;

    // Output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_last;

    t_ctrl             ctrl;
    t_flags            flags;
    logic [STEP_W-1:0] step;
    logic              in_accept;

    logic [SAMPLE_W-1:0]               win;
    logic signed [SAMPLE_W+KERN_W-1:0] tap_prod;
    logic signed [SAMPLE_W+KERN_W-1:0] pass_prod;
    logic signed [PROD_W-SHIFT-1:0]    shifted;
    logic signed [DATA_W:0]            sum;
    logic signed [DATA_W-1:0]          sat;

    localparam logic signed [DATA_W:0] SAT_MAX = {2'b00, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W:0] SAT_MIN = {2'b11, {(DATA_W-1){1'b0}}};

    sincx5_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .o_step  (step)
    );

    // Take a new sample only while the program sits in its wait step, never in reset
    assign o_ready   = i_rst_n && (ctrl.op == OP_ACCEPT);
    assign in_accept = i_valid && o_ready;

    always_comb begin
        flags.no_in      = !i_valid;
        flags.cold       = r_up && (r_fill < TAP_W'(TAPS - 1));
        flags.up         = r_up;
        flags.tap_more   = (r_tap != TAP_W'(TAPS - 1));
        flags.out_busy   = r_out_valid && !i_ready;
        flags.phase_more = r_up && (r_phase != '0);
    end

    // Window: the nine held samples, newest sample as the last tap
    always_comb begin
        win = r_sample;
        for (int k = 0; k < TAPS - 1; k++) begin
            if (r_tap == TAP_W'(k)) begin
                win = r_delay[k];
            end
        end
    end

    assign tap_prod  = $signed({1'b0, win}) * kern(r_tap, r_phase);
    assign pass_prod = $signed({1'b0, r_sample}) * PASS_KERN;

    // Floor shift then offset, saturate to 32 bits
    assign shifted = r_prod[PROD_W-1:SHIFT];
    assign sum     = (DATA_W+1)'(shifted) + (DATA_W+1)'(r_offset);

    always_comb begin
        priority if (sum > SAT_MAX) begin
            sat = SAT_MAX[DATA_W-1:0];
        end else if (sum < SAT_MIN) begin
            sat = SAT_MIN[DATA_W-1:0];
        end else begin
            sat = sum[DATA_W-1:0];
        end
    end

    // Configuration writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up     <= 1'b0;
            r_gain   <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_UPSAMPLE) r_up     <= i_cfg_data[0];
            if (i_cfg_index == REG_GAIN)     r_gain   <= i_cfg_data;
            if (i_cfg_index == REG_OFFSET)   r_offset <= i_cfg_data;
        end
    end

    // Delay line and fill count: advance once per sample at the end of its program
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int k = 0; k < TAPS - 1; k++) begin
                r_delay[k] <= '0;
            end
        end else if (ctrl.op == OP_UPDATE) begin
            for (int k = 0; k < TAPS - 2; k++) begin
                r_delay[k] <= r_delay[k+1];
            end
            r_delay[TAPS-2] <= r_sample;
            if (r_fe) begin
                r_fill <= '0;
            end else if (r_fill < TAP_W'(TAPS - 1)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // Datapath: hold the transaction, run init, pass, MAC, multiply, scale and next-phase steps
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_sample;
            r_fe     <= i_frame_end;
        end
        unique case (ctrl.op)
            OP_INIT: begin
                r_acc   <= '0;
                r_tap   <= '0;
                r_phase <= PH_W'(PHASES - 1);
            end
            OP_PASS: begin
                r_acc <= ACC_W'(pass_prod);
            end
            OP_MAC: begin
                r_acc <= r_acc + ACC_W'(tap_prod);
                r_tap <= r_tap + 1'b1;
            end
            OP_MUL: begin
                r_prod <= r_gain * PROD_W'(r_acc);
            end
            OP_SCALE: begin
                r_res <= sat;
            end
            OP_NEXT: begin
                if (flags.phase_more) begin
                    r_acc   <= '0;
                    r_tap   <= '0;
                    r_phase <= r_phase - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load on the emit step once the slot is free, drop valid when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == OP_EMIT && !flags.out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == OP_EMIT && !flags.out_busy) begin
            r_out_value <= r_res;
            r_out_last  <= r_fe && (!r_up || r_phase == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> step == ST_INIT)
        else $error("accepted transaction did not start the program");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= TAP_W'(TAPS - 1))
        else $error("fill count beyond window depth");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == OP_EMIT && !flags.out_busy) |=> o_valid)
        else $error("emit step did not present a result");

    a_mac_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.op == OP_MAC |-> r_tap <= TAP_W'(TAPS - 1))
        else $error("tap index ran past the window");

endmodule
